// ===== src/gcd_pkg.sv =====
`default_nettype none

package gcd_pkg;

   localparam int CW = 34;
   localparam int SQRT_STEPS = 31;

   localparam logic signed [26:0] DEG_FULL = 27'sd23592960;
   localparam logic signed [26:0] DEG_HALF = 27'sd11796480;
   localparam logic signed [26:0] DEG_QUARTER = 27'sd5898240;

   localparam logic [63:0] PI_Q32 = 64'h3243F6A89;
   localparam logic [31:0] DEG_RAD_K = 32'((PI_Q32 * 64'd8) / 64'd45);
   localparam logic [26:0] RAD_P_LO = 27'(PI_Q32);
   localparam logic [26:0] RAD_ROUND = 27'(90 << 18);
   localparam logic [54:0] RAD_QUOT_BIAS = 55'(1) << 22;
   localparam logic [8:0] RAD_DEN_UNIT = 9'd180;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh26DD3B6A;
   localparam logic signed [CW-1:0] PI_Q30 = 34'shC90FDAA2;
   localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;
   localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;
   localparam logic [60:0] ONE_SQ = 61'(1) << 60;

   localparam logic [22:0] EARTH_RADIUS_M = 23'd6371000;
   localparam logic [24:0] HALF_CIRC_M = 25'd20015087;

   typedef struct packed {
      logic signed [31:0] sin_a;
      logic signed [31:0] cos_a;
      logic signed [31:0] sin_b;
      logic signed [31:0] cos_b;
      logic signed [31:0] cos_d;
   } trig_type;

   typedef struct packed {
      logic [60:0] radicand;
      logic [30:0] abs_c;
      logic        c_pos;
   } root_req_type;

   typedef struct packed {
      logic [30:0] root;
      logic [30:0] abs_c;
      logic        c_pos;
   } vec_req_type;

   function automatic logic [31:0] atan_at(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'h3243F6A8;
         1: v = 32'h1DAC6705;
         2: v = 32'h0FADBAFC;
         3: v = 32'h07F56EA6;
         4: v = 32'h03FEAB76;
         5: v = 32'h01FFD55B;
         6: v = 32'h00FFFAAA;
         7: v = 32'h007FFF55;
         8: v = 32'h003FFFEA;
         9: v = 32'h001FFFFD;
         10: v = 32'h000FFFFF;
         11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF;
         13: v = 32'h0001FFFF;
         14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF;
         16: v = 32'h00003FFF;
         17: v = 32'h00001FFF;
         18: v = 32'h00000FFF;
         19: v = 32'h000007FF;
         20: v = 32'h000003FF;
         21: v = 32'h000001FF;
         22: v = 32'h000000FF;
         23: v = 32'h0000007F;
         24: v = 32'h0000003F;
         25: v = 32'h0000001F;
         26: v = 32'h0000000F;
         27: v = 32'h00000008;
         28: v = 32'h00000004;
         29: v = 32'h00000002;
         30: v = 32'h00000001;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== src/gcd_sincos.sv =====
`default_nettype none

module gcd_sincos import gcd_pkg::*; #(
   parameter int STAGES = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic signed [23:0] lat_a,
   input  wire logic signed [24:0] lon_a,
   input  wire logic signed [23:0] lat_b,
   input  wire logic signed [24:0] lon_b,
   output logic                    out_valid,
   output trig_type                out_trig
);

   logic [STAGES+5:0] vld_ff, vld_in;
   logic signed [26:0] ang [3];
   logic signed [24:0] wrap_in [3], wrap_ff [3];
   logic [22:0] mag_in [3], mag_ff [3];
   logic [2:0] zneg_in, zneg2_ff, zneg3_ff, zneg4_ff;
   logic [2:0] cneg_in, cneg2_ff, cneg3_ff, cneg4_ff;
   logic [54:0] pk_in [3], pk_ff [3];
   logic [26:0] pl_in [3], pl_ff [3];
   logic [31:0] q_in [3], q_ff [3];
   logic [2:0] bump_in, bump_ff;
   logic signed [CW-1:0] cx_ff [STAGES+1][3];
   logic signed [CW-1:0] cy_ff [STAGES+1][3];
   logic signed [CW-1:0] cz_ff [STAGES+1][3];
   logic [2:0] cn_ff [STAGES+1];
   logic signed [CW-1:0] z0_in [3];
   trig_type out_in, out_ff;

   assign vld_in = {vld_ff[STAGES+4:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign ang[0] = 27'(lat_a);
   assign ang[1] = 27'(lat_b);
   assign ang[2] = 27'(lon_a) - 27'(lon_b);

   always_comb begin
      logic signed [26:0] w;
      for (int l = 0; l < 3; l++) begin
         w = ang[l];
         if (w >= DEG_FULL) begin
            w = w - DEG_FULL;
         end else if (w <= -DEG_FULL) begin
            w = w + DEG_FULL;
         end
         if (w > DEG_HALF) begin
            w = w - DEG_FULL;
         end else if (w <= -DEG_HALF) begin
            w = w + DEG_FULL;
         end
         wrap_in[l] = 25'(w);
      end
   end

   always_comb begin
      logic signed [24:0] d;
      logic fold;
      for (int l = 0; l < 3; l++) begin
         d = wrap_ff[l];
         fold = 1'b0;
         if (d > DEG_QUARTER) begin
            d = 25'(DEG_HALF - 27'(d));
            fold = 1'b1;
         end else if (d < -DEG_QUARTER) begin
            d = 25'(-DEG_HALF - 27'(d));
            fold = 1'b1;
         end
         cneg_in[l] = fold;
         zneg_in[l] = d[24];
         mag_in[l] = d[24] ? 23'(-d) : 23'(d);
      end
   end

   always_comb begin
      logic [54:0] s;
      logic [31:0] qinc;
      logic [26:0] diff;
      for (int l = 0; l < 3; l++) begin
         pk_in[l] = 55'(mag_ff[l]) * 55'(DEG_RAD_K);
         pl_in[l] = 27'(27'(mag_ff[l]) * RAD_P_LO);
         s = pk_ff[l] + RAD_QUOT_BIAS;
         q_in[l] = 32'(s >> 23);
         qinc = q_in[l] + 32'd1;
         diff = pl_ff[l] + RAD_ROUND - {9'(qinc[8:0] * RAD_DEN_UNIT), 18'b0};
         bump_in[l] = !diff[26];
      end
   end

   always_comb begin
      logic signed [CW-1:0] r;
      for (int l = 0; l < 3; l++) begin
         r = $signed(CW'(q_ff[l])) + $signed(CW'(bump_ff[l]));
         z0_in[l] = zneg4_ff[l] ? -r : r;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wrap_ff <= wrap_in;
         mag_ff <= mag_in;
         zneg2_ff <= zneg_in;
         cneg2_ff <= cneg_in;
         pk_ff <= pk_in;
         pl_ff <= pl_in;
         zneg3_ff <= zneg2_ff;
         cneg3_ff <= cneg2_ff;
         q_ff <= q_in;
         bump_ff <= bump_in;
         zneg4_ff <= zneg3_ff;
         cneg4_ff <= cneg3_ff;
         for (int l = 0; l < 3; l++) begin
            cx_ff[0][l] <= CORDIC_GAIN;
            cy_ff[0][l] <= '0;
            cz_ff[0][l] <= z0_in[l];
         end
         cn_ff[0] <= cneg4_ff;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      localparam logic signed [CW-1:0] ATAN_I = CW'(atan_at(i));
      logic signed [CW-1:0] x_in [3], y_in [3], z_in [3];

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if (cz_ff[i][l] >= 0) begin
               x_in[l] = cx_ff[i][l] - (cy_ff[i][l] >>> i);
               y_in[l] = cy_ff[i][l] + (cx_ff[i][l] >>> i);
               z_in[l] = cz_ff[i][l] - ATAN_I;
            end else begin
               x_in[l] = cx_ff[i][l] + (cy_ff[i][l] >>> i);
               y_in[l] = cy_ff[i][l] - (cx_ff[i][l] >>> i);
               z_in[l] = cz_ff[i][l] + ATAN_I;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 3; l++) begin
               cx_ff[i+1][l] <= x_in[l];
               cy_ff[i+1][l] <= y_in[l];
               cz_ff[i+1][l] <= z_in[l];
            end
            cn_ff[i+1] <= cn_ff[i];
         end
      end
   end

   always_comb begin
      out_in.sin_a = 32'(cy_ff[STAGES][0]);
      out_in.sin_b = 32'(cy_ff[STAGES][1]);
      out_in.cos_a = cn_ff[STAGES][0] ? 32'(-cx_ff[STAGES][0]) : 32'(cx_ff[STAGES][0]);
      out_in.cos_b = cn_ff[STAGES][1] ? 32'(-cx_ff[STAGES][1]) : 32'(cx_ff[STAGES][1]);
      out_in.cos_d = cn_ff[STAGES][2] ? 32'(-cx_ff[STAGES][2]) : 32'(cx_ff[STAGES][2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_trig = out_ff;
   assign out_valid = vld_ff[STAGES+5];

endmodule

`default_nettype wire

// ===== src/gcd_prod.sv =====
`default_nettype none

module gcd_prod import gcd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   en,
   input  wire logic   in_valid,
   input  trig_type    in_trig,
   output logic        out_valid,
   output root_req_type out_req
);

   logic [5:0] vld_ff, vld_in;
   logic signed [63:0] p1_in, p1_ff, p2_in, p2_ff, p3_in, p3_ff;
   logic signed [31:0] cd1_ff, cd2_ff;
   logic signed [31:0] t1_in, t1_ff, t1b_ff, t2_in, t2_ff;
   logic signed [31:0] c_in, c_ff;
   logic [30:0] ac_in, ac_ff;
   logic cp_ff;
   logic [60:0] sq_in, sq_ff, rad_in;
   root_req_type out_ff;

   assign vld_in = {vld_ff[4:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign p1_in = $signed(in_trig.sin_a) * $signed(in_trig.sin_b);
   assign p2_in = $signed(in_trig.cos_a) * $signed(in_trig.cos_b);
   assign t1_in = 32'((p1_ff + HALF_Q30) >>> 30);
   assign t2_in = 32'((p2_ff + HALF_Q30) >>> 30);
   assign p3_in = t2_ff * cd2_ff;

   always_comb begin
      logic signed [CW-1:0] t3;
      logic signed [CW-1:0] s;
      t3 = CW'((p3_ff + HALF_Q30) >>> 30);
      s = CW'(t1b_ff) + t3;
      if (s > ONE_Q30) begin
         s = ONE_Q30;
      end else if (s < -ONE_Q30) begin
         s = -ONE_Q30;
      end
      c_in = 32'(s);
   end

   assign ac_in = c_ff[31] ? 31'(-c_ff) : 31'(c_ff);
   assign sq_in = 61'(ac_in) * 61'(ac_in);
   assign rad_in = ONE_SQ - sq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         cd1_ff <= in_trig.cos_d;
         t1_ff <= t1_in;
         t2_ff <= t2_in;
         cd2_ff <= cd1_ff;
         p3_ff <= p3_in;
         t1b_ff <= t1_ff;
         c_ff <= c_in;
         ac_ff <= ac_in;
         cp_ff <= !c_ff[31];
         sq_ff <= sq_in;
         out_ff.radicand <= rad_in;
         out_ff.abs_c <= ac_ff;
         out_ff.c_pos <= cp_ff;
      end
   end

   assign out_req = out_ff;
   assign out_valid = vld_ff[5];

endmodule

`default_nettype wire

// ===== src/gcd_isqrt.sv =====
`default_nettype none

module gcd_isqrt import gcd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    en,
   input  wire logic    in_valid,
   input  root_req_type in_req,
   output logic         out_valid,
   output vec_req_type  out_req
);

   logic [SQRT_STEPS:1] vld_ff;
   logic cp_ff [1:SQRT_STEPS];
   logic [61:0] v_ff [1:SQRT_STEPS];
   logic [61:0] r_ff [1:SQRT_STEPS];
   logic [30:0] ac_ff [1:SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[SQRT_STEPS-1:1], in_valid};
      end
   end

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      localparam logic [61:0] BIT = 62'(1) << (2 * (SQRT_STEPS - 1 - i));
      logic [61:0] v_cur, r_cur, v_in, r_in, t;
      logic [30:0] ac_cur;
      logic cp_cur;

      if (i == 0) begin : g_first
         assign v_cur = 62'(in_req.radicand);
         assign r_cur = '0;
         assign ac_cur = in_req.abs_c;
         assign cp_cur = in_req.c_pos;
      end else begin : g_next
         assign v_cur = v_ff[i];
         assign r_cur = r_ff[i];
         assign ac_cur = ac_ff[i];
         assign cp_cur = cp_ff[i];
      end

      assign t = r_cur + BIT;

      always_comb begin
         if (v_cur >= t) begin
            v_in = v_cur - t;
            r_in = (r_cur >> 1) + BIT;
         end else begin
            v_in = v_cur;
            r_in = r_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[i+1] <= v_in;
            r_ff[i+1] <= r_in;
            ac_ff[i+1] <= ac_cur;
            cp_ff[i+1] <= cp_cur;
         end
      end
   end

   assign out_req.root = 31'(r_ff[SQRT_STEPS]);
   assign out_req.abs_c = ac_ff[SQRT_STEPS];
   assign out_req.c_pos = cp_ff[SQRT_STEPS];
   assign out_valid = vld_ff[SQRT_STEPS];

endmodule

`default_nettype wire

// ===== src/gcd_acos.sv =====
`default_nettype none

module gcd_acos import gcd_pkg::*; #(
   parameter int STAGES = 24
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   en,
   input  wire logic   in_valid,
   input  vec_req_type in_req,
   output logic        out_valid,
   output logic [24:0] distance_m
);

   logic [STAGES+3:1] vld_ff;
   logic cp_ff [1:STAGES];
   logic signed [CW-1:0] x_ff [1:STAGES];
   logic signed [CW-1:0] y_ff [1:STAGES];
   logic signed [CW-1:0] z_ff [1:STAGES];
   logic [31:0] th_in, th_ff;
   logic [54:0] m_in, m_ff;
   logic [24:0] dist_in, dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES+2:1], in_valid};
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_vec
      localparam logic signed [CW-1:0] ATAN_I = CW'(atan_at(i));
      logic signed [CW-1:0] x_cur, y_cur, z_cur, x_in, y_in, z_in;
      logic cp_cur;

      if (i == 0) begin : g_first
         assign x_cur = $signed(CW'(in_req.abs_c));
         assign y_cur = $signed(CW'(in_req.root));
         assign z_cur = '0;
         assign cp_cur = in_req.c_pos;
      end else begin : g_next
         assign x_cur = x_ff[i];
         assign y_cur = y_ff[i];
         assign z_cur = z_ff[i];
         assign cp_cur = cp_ff[i];
      end

      always_comb begin
         if (y_cur > 0) begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            z_in = z_cur + ATAN_I;
         end else begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            z_in = z_cur - ATAN_I;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
            cp_ff[i+1] <= cp_cur;
         end
      end
   end

   always_comb begin
      logic signed [CW-1:0] th;
      th = cp_ff[STAGES] ? z_ff[STAGES] : PI_Q30 - z_ff[STAGES];
      if (th < 0) begin
         th = '0;
      end else if (th > PI_Q30) begin
         th = PI_Q30;
      end
      th_in = 32'(th);
   end

   assign m_in = 55'(th_ff) * 55'(EARTH_RADIUS_M);

   always_comb begin
      logic [54:0] s;
      s = (m_ff + 55'(HALF_Q30)) >> 30;
      dist_in = (s > 55'(HALF_CIRC_M)) ? HALF_CIRC_M : 25'(s);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         th_ff <= th_in;
         m_ff <= m_in;
         dist_ff <= dist_in;
      end
   end

   assign distance_m = dist_ff;
   assign out_valid = vld_ff[STAGES+3];

endmodule

`default_nettype wire

// ===== src/great_circle_distance.sv =====
// Great-circle distance between two points on a sphere of radius 6371 km.
// The req channel carries one point pair per transaction: two latitudes and
// two longitudes in signed degrees times 65536. The rsp channel returns the
// distance in whole metres, saturated at half the circumference.
// Angles are reduced, converted to radians and fed to three parallel CORDIC
// rotators for the sines and cosines; the products and the clamped cosine sum
// follow, then a pipelined square root and a CORDIC vectoring unit for acos.
// The two CORDIC pipelines and the 31-step square root make up most of the
// register stages of the pipeline.
// Throughput is one transaction per cycle unless the output stalls; every
// stage is a register stage and holds at most one transaction in flight.
// Reset clears all valid bits; the block takes a transaction in the first
// cycle after reset is released.
// When the receiver holds rsp_tready low while a result waits, the whole
// pipeline holds and req_tready drops in the same cycle; nothing is lost or
// repeated.
`default_nettype none

module great_circle_distance import gcd_pkg::*; #(
   parameter int CORDIC_STAGES = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [103:0] req_tdata,  // lat_a, lon_a, lat_b, lon_b, zero fill
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata   // distance_m, zero fill
);

   logic advance;
   logic sc_valid, pr_valid, sq_valid;
   trig_type trig;
   root_req_type root_req;
   vec_req_type vec_req;
   logic [24:0] distance_m;

   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sincos (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (req_tvalid),
      .lat_a     ($signed(req_tdata[23:0])),
      .lon_a     ($signed(req_tdata[48:24])),
      .lat_b     ($signed(req_tdata[72:49])),
      .lon_b     ($signed(req_tdata[97:73])),
      .out_valid (sc_valid),
      .out_trig  (trig)
   );

   gcd_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (sc_valid),
      .in_trig   (trig),
      .out_valid (pr_valid),
      .out_req   (root_req)
   );

   gcd_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (pr_valid),
      .in_req    (root_req),
      .out_valid (sq_valid),
      .out_req   (vec_req)
   );

   gcd_acos #(.STAGES(CORDIC_STAGES)) u_acos (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .in_valid   (sq_valid),
      .in_req     (vec_req),
      .out_valid  (rsp_tvalid),
      .distance_m (distance_m)
   );

   assign rsp_tdata = {7'b0, distance_m};

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> distance_m <= HALF_CIRC_M)
      else $error("distance above half circumference");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while the output is stalled");

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import gcd_pkg::*;

   typedef struct packed {
      logic signed [24:0] lon_b;
      logic signed [23:0] lat_b;
      logic signed [24:0] lon_a;
      logic signed [23:0] lat_a;
   } point_pair_type;

   localparam longint DEG = 65536;
   localparam int CYCLE_LIMIT = 600000;

   class distance_scoreboard;
      logic [24:0] expected_m[$];
      int errors;
      int checked;

      function longint shr(longint v, int s);
         return v >>> s;
      endfunction

      function longint atan_q30(int i);
         return longint'(atan_at(i));
      endfunction

      function longint to_radians(longint d);
         longint unsigned mag;
         longint unsigned den;
         longint unsigned r;
         mag = d < 0 ? -d : d;
         den = 64'd180 << 18;
         r = (mag * PI_Q32 + den / 2) / den;
         return d < 0 ? -longint'(r) : longint'(r);
      endfunction

      function void rotate(input longint deg, output longint sn, output longint cs);
         longint full;
         longint half;
         longint quarter;
         longint d;
         longint x;
         longint y;
         longint z;
         longint xs;
         longint ys;
         bit flip;
         full = 360 * DEG;
         half = 180 * DEG;
         quarter = 90 * DEG;
         flip = 0;
         d = deg % full;
         if (d > half) d -= full;
         if (d <= -half) d += full;
         if (d > quarter) begin
            d = half - d;
            flip = 1;
         end else if (d < -quarter) begin
            d = -half - d;
            flip = 1;
         end
         z = to_radians(d);
         x = longint'(CORDIC_GAIN);
         y = 0;
         for (int i = 0; i < 24; i++) begin
            xs = shr(x, i);
            ys = shr(y, i);
            if (z >= 0) begin
               x -= ys; y += xs; z -= atan_q30(i);
            end else begin
               x += ys; y -= xs; z += atan_q30(i);
            end
         end
         sn = y;
         cs = flip ? -x : x;
      endfunction

      function longint mul_q30(longint a, longint b);
         return shr(a * b + 64'sd536870912, 30);
      endfunction

      function longint unsigned root(longint unsigned v);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function longint arc_cos(longint c);
         longint ac;
         longint x;
         longint y;
         longint z;
         longint xs;
         longint ys;
         longint th;
         longint pi;
         pi = longint'(PI_Q30);
         ac = c < 0 ? -c : c;
         x = ac;
         z = 0;
         y = longint'(root((64'd1 << 60) - longint'(ac * ac)));
         for (int i = 0; i < 24; i++) begin
            xs = shr(x, i);
            ys = shr(y, i);
            if (y > 0) begin
               x += ys; y -= xs; z += atan_q30(i);
            end else begin
               x -= ys; y += xs; z -= atan_q30(i);
            end
         end
         th = c >= 0 ? z : pi - z;
         if (th < 0) th = 0;
         if (th > pi) th = pi;
         return th;
      endfunction

      function logic [24:0] distance(point_pair_type p);
         longint sa, ca, sb, cb, sd, cd, c, th, one;
         longint unsigned m;
         one = 64'sd1 << 30;
         rotate(longint'(p.lat_a), sa, ca);
         rotate(longint'(p.lat_b), sb, cb);
         rotate(longint'(p.lon_a) - longint'(p.lon_b), sd, cd);
         c = mul_q30(sa, sb) + mul_q30(mul_q30(ca, cb), cd);
         if (c > one) c = one;
         if (c < -one) c = -one;
         th = arc_cos(c);
         m = (longint'(th) * 64'd6371000 + 64'd536870912) >> 30;
         if (m > HALF_CIRC_M) m = HALF_CIRC_M;
         return m[24:0];
      endfunction

      function void note_request(point_pair_type p);
         expected_m.push_back(distance(p));
      endfunction

      function void check_response(logic [31:0] data);
         logic [24:0] want;
         if (expected_m.size() == 0) begin
            $display("%0t: unexpected distance %0d", $time, data[24:0]);
            errors++;
            return;
         end
         want = expected_m.pop_front();
         checked++;
         if (data[24:0] !== want) begin
            $display("%0t: distance_m expected %0d actual %0d", $time, want, data[24:0]);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [103:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [31:0] rsp_tdata;

   int send_idle_pct;
   int stall_pct;
   int cycles;
   int sent;
   distance_scoreboard board;

   great_circle_distance u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(point_pair_type'(req_tdata[97:0]));
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("great_circle_distance regression: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_pair(point_pair_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'b0, p};
      do @(posedge clock); while (!req_tready);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_coords(longint la, longint loa, longint lb, longint lob);
      point_pair_type p;
      p.lat_a = 24'(la);
      p.lon_a = 25'(loa);
      p.lat_b = 24'(lb);
      p.lon_b = 25'(lob);
      send_pair(p);
   endtask

   function automatic longint wrap_lon(longint v);
      if (v > 180 * DEG) v -= 360 * DEG;
      if (v < -180 * DEG) v += 360 * DEG;
      return v;
   endfunction

   function automatic longint rand_range(longint lim);
      return longint'($urandom_range(32'(2 * lim))) - lim;
   endfunction

   task automatic send_random();
      point_pair_type p;
      int kind;
      kind = $urandom_range(99);
      p.lat_a = 24'(rand_range(90 * DEG));
      p.lon_a = 25'(rand_range(180 * DEG));
      p.lat_b = 24'(rand_range(90 * DEG));
      p.lon_b = 25'(rand_range(180 * DEG));
      if (kind < 15) begin
         p.lat_a = 24'($urandom);
         p.lon_a = 25'($urandom);
         p.lat_b = 24'($urandom);
         p.lon_b = 25'($urandom);
      end else if (kind < 25) begin
         p.lat_b = 24'(longint'(p.lat_a) + rand_range(64));
         p.lon_b = 25'(wrap_lon(longint'(p.lon_a) + rand_range(64)));
      end else if (kind < 35) begin
         p.lat_b = 24'(-longint'(p.lat_a) + rand_range(64));
         p.lon_b = 25'(wrap_lon(longint'(p.lon_a) + 180 * DEG + rand_range(64)));
      end else if (kind < 45) begin
         p.lat_b = 24'(longint'(p.lat_a) + rand_range(DEG));
         p.lon_b = 25'(wrap_lon(longint'(p.lon_a) + rand_range(DEG)));
      end
      send_pair(p);
   endtask

   task automatic wait_drained();
      while (board.expected_m.size() != 0) @(negedge clock);
   endtask

   initial begin
      board = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_coords(0, 0, 0, 0);
      send_coords(90 * DEG, 0, -90 * DEG, 0);
      send_coords(90 * DEG, 0, 90 * DEG, 180 * DEG);
      send_coords(0, 0, 0, 180 * DEG);
      send_coords(0, -180 * DEG, 0, 180 * DEG);
      send_coords(0, 180 * DEG, 0, -180 * DEG + 1);
      send_coords(45 * DEG, 10 * DEG, -45 * DEG, -170 * DEG);
      send_coords(-90 * DEG, -180 * DEG, 90 * DEG, 180 * DEG);
      send_coords(51 * DEG, 0, 51 * DEG, 1);
      send_coords(1, 1, 0, 0);
      send_coords(-(1 << 23), -(1 << 24), (1 << 23) - 1, (1 << 24) - 1);
      send_coords((1 << 23) - 1, (1 << 24) - 1, -(1 << 23), -(1 << 24));
      send_coords(120 * DEG, 0, 60 * DEG, 0);
      send_coords(-100 * DEG, 250 * DEG, 10 * DEG, -200 * DEG);
      send_coords(30 * DEG, 90 * DEG, 30 * DEG, -90 * DEG);
      send_coords(12345678, -7654321, -2345678, 11796480);
      send_coords(0, 0, 1, 0);
      send_coords(-5898240, 11796480, 5898240, -11796480);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 76 : 29) : 0;
         stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 76 : 29) : 0;
         for (int n = 0; n < 420; n++) begin
            send_random();
            if (n == 200) begin
               req_tvalid <= 0;
               wait_drained();
            end
         end
      end
      req_tvalid <= 0;
      send_idle_pct = 0;
      stall_pct = 0;
      wait_drained();
      repeat (150) @(negedge clock);

      $display("Sent %0d point pairs, checked %0d distances across four idle and stall mixes.",
               sent, board.checked);
      if (board.errors == 0 && board.expected_m.size() == 0) begin
         $display("great_circle_distance regression: pass");
      end else begin
         $display("great_circle_distance regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/gcd_pkg.sv
src/gcd_sincos.sv
src/gcd_prod.sv
src/gcd_isqrt.sv
src/gcd_acos.sv
src/great_circle_distance.sv
tb/sv/testbench.sv
